// File: rtl/core/svws_pkg.sv
// shared constants, types and command/status bundles of the servo waypoint scheduler
// no dependencies; used by every module under rtl/core
package svws_pkg;

   localparam int NUM_SERVOS            = 20;
   localparam int QUEUE_DEPTH           = 8;
   localparam int TIME_UNITS_PER_SECOND = 1000000;

   localparam int SERVO_W = 5;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 16;
   localparam int SPEED_W = 16;
   localparam int IDX_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS   = NUM_SERVOS * QUEUE_DEPTH;
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TUPS_W  = $clog2(TIME_UNITS_PER_SECOND + 1);
   localparam int NUM_W   = POS_W + TUPS_W;
   localparam int DEN_W   = TIME_W + 4;
   localparam int DIV_W   = (NUM_W > DEN_W + SPEED_W) ? NUM_W : DEN_W + SPEED_W;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_ALL    = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] t_start;
      logic [TIME_W-1:0] t_end;
      logic [POS_W-1:0]  goal;
      logic [15:0]       gain;
      logic              started;
   } entry_type;

   typedef struct packed {
      logic     latch;
      logic     pres_wr;
      logic     rd_back;
      logic     rd_front;
      logic     trim_dec;
      logic     append;
      logic     idx_clr;
      logic     idx_inc;
      logic     pop;
      logic     flag_clr;
      logic     note_count;
      logic     mark;
      logic     div_start;
      logic     emit;
      kind_type kind;
      logic     flush;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       servo_ok;
      logic       cnt_zero;
      logic       cnt_one;
      logic       cnt_full;
      logic       trim_hit;
      logic       retire_hit;
      logic       start_hit;
      logic       idx_last;
      logic       all_done;
      logic       div_done;
      logic       can_emit;
      logic       pend_valid;
   } stat_type;

endpackage

// File: rtl/core/svws_divider.sv
// iterative speed divider: floor(diff * units_per_second / den), saturated to 16 bits
// depends on svws_pkg
module svws_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [svws_pkg::POS_W-1:0]  diff,
   input  logic [svws_pkg::DEN_W-1:0]  den,
   output logic [svws_pkg::SPEED_W-1:0] quot,
   output logic                        done
);
   import svws_pkg::*;

   localparam int QSTEPS = SPEED_W + 1;
   localparam int STEP_W = $clog2(QSTEPS + 1);
   localparam logic [TUPS_W-1:0] TUPS_V = TUPS_W'(TIME_UNITS_PER_SECOND);

   logic [DIV_W-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QSTEPS-1:0]  q_ff, q_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic [NUM_W-1:0]   prod;
   logic               ge;

   assign prod = NUM_W'(diff) * NUM_W'(TUPS_V);
   assign ge   = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = DIV_W'(prod);
         dsh_in  = DIV_W'(den) << SPEED_W;
         q_in    = '0;
         step_in = STEP_W'(QSTEPS);
         busy_in = 1'b1;
      end else if (busy_ff && step_ff != '0) begin
         rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in  = dsh_ff >> 1;
         q_in    = {q_ff[QSTEPS-2:0], ge};
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done = busy_ff && (step_ff == '0);
   assign quot = q_ff[QSTEPS-1] ? '1 : q_ff[SPEED_W-1:0];

endmodule

// File: rtl/core/svws_datapath.sv
// datapath: request latch, queue pointers, waypoint memory, speed divider, result buffer
// depends on svws_pkg and svws_divider
module svws_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_action,
   input  logic [svws_pkg::SERVO_W-1:0]  req_servo_id,
   input  logic [svws_pkg::TIME_W-1:0]   req_now_time,
   input  logic [svws_pkg::TIME_W-1:0]   req_target_time,
   input  logic signed [svws_pkg::POS_W-1:0] req_target_position,
   input  logic [15:0]                   req_target_gain,
   input  logic signed [svws_pkg::POS_W-1:0] req_sensed_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [svws_pkg::SERVO_W-1:0]  rsp_out_servo,
   output logic signed [svws_pkg::POS_W-1:0] rsp_goal_position,
   output logic [svws_pkg::SPEED_W-1:0]  rsp_moving_speed,
   output logic [15:0]                   rsp_p_gain,
   output logic                          rsp_last,
   input  svws_pkg::cmd_type             cmd,
   output svws_pkg::stat_type            st
);
   import svws_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic [SERVO_W-1:0] servo;
      logic [POS_W-1:0]   goal;
      logic [SPEED_W-1:0] speed;
      logic [15:0]        gain;
   } res_type;

   function automatic logic [HEAD_W-1:0] wrap(input logic [HEAD_W-1:0] h,
                                             input logic [CNT_W-1:0] k);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(h) + (CNT_W+1)'(k);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      return HEAD_W'(sum);
   endfunction

   // latched request
   logic [1:0]         act_ff;
   logic [SERVO_W-1:0] sid_ff;
   logic [TIME_W-1:0]  now_ff, ttime_ff;
   logic [POS_W-1:0]   tpos_ff, spos_ff;
   logic [15:0]        tgain_ff;

   logic [CNT_W-1:0]   cnt_ff  [NUM_SERVOS];
   logic [HEAD_W-1:0]  head_ff [NUM_SERVOS];
   logic [POS_W-1:0]   pres_ff [NUM_SERVOS];
   entry_type          mem     [SLOTS];
   entry_type          rd_ff;

   logic [IDX_W-1:0]   idx_ff, sel, sid_idx;
   logic               emptied_ff, nonempty_ff;
   logic [CNT_W-1:0]   c;
   logic [HEAD_W-1:0]  h;
   logic [ADDR_W-1:0]  base, f_addr, back_addr, app_addr, rd_addr;
   entry_type          new_entry, marked;

   logic               pend_v_ff, rsp_v_ff;
   res_type            pend_ff, res_new, out_ff;
   logic               last_ff;

   logic [POS_W:0]     dsigned;
   logic [POS_W-1:0]   diff;
   logic [DEN_W-1:0]   den;
   logic [SPEED_W-1:0] div_q, speed;
   logic               div_done;

   assign sid_idx   = sid_ff[IDX_W-1:0];
   assign sel       = (act_ff == ACT_TICK) ? idx_ff : sid_idx;
   assign c         = cnt_ff[sel];
   assign h         = head_ff[sel];
   assign base      = ADDR_W'(sel * QUEUE_DEPTH);
   assign f_addr    = base + ADDR_W'(h);
   assign back_addr = base + ADDR_W'(wrap(h, c - 1'b1));
   assign app_addr  = base + ADDR_W'(wrap(h, c));
   assign rd_addr   = cmd.rd_back ? back_addr : f_addr;

   always_comb begin
      new_entry.t_start = (c == '0) ? now_ff : rd_ff.t_end;
      new_entry.t_end   = ttime_ff;
      new_entry.goal    = tpos_ff;
      new_entry.gain    = tgain_ff;
      new_entry.started = 1'b0;
      marked            = rd_ff;
      marked.started    = 1'b1;
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff   <= req_action;
         sid_ff   <= req_servo_id;
         now_ff   <= req_now_time;
         ttime_ff <= req_target_time;
         tpos_ff  <= req_target_position;
         tgain_ff <= req_target_gain;
         spos_ff  <= req_sensed_position;
      end
   end

   // queue pointers, present angles, pass index and tick flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            cnt_ff[i]  <= '0;
            head_ff[i] <= '0;
            pres_ff[i] <= '0;
         end
         idx_ff      <= '0;
         emptied_ff  <= 1'b0;
         nonempty_ff <= 1'b0;
      end else begin
         if (cmd.pres_wr) pres_ff[sid_idx] <= spos_ff;
         if (cmd.trim_dec || cmd.pop) cnt_ff[sel] <= c - 1'b1;
         else if (cmd.append) cnt_ff[sel] <= c + 1'b1;
         if (cmd.pop) head_ff[sel] <= wrap(h, CNT_W'(1));
         if (cmd.idx_clr) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
         if (cmd.flag_clr) begin
            emptied_ff  <= 1'b0;
            nonempty_ff <= 1'b0;
         end else begin
            if (cmd.pop && c == CNT_W'(1)) emptied_ff <= 1'b1;
            if (cmd.note_count && c != '0) nonempty_ff <= 1'b1;
         end
      end
   end

   // waypoint memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.append) mem[app_addr] <= new_entry;
      else if (cmd.mark) mem[f_addr] <= marked;
      if (cmd.rd_back || cmd.rd_front) rd_ff <= mem[rd_addr];
   end

   // speed
   assign dsigned = {rd_ff.goal[POS_W-1], rd_ff.goal}
                  - {pres_ff[sel][POS_W-1], pres_ff[sel]};
   assign diff    = dsigned[POS_W] ? POS_W'(-dsigned) : dsigned[POS_W-1:0];
   assign den     = {rd_ff.t_end - now_ff, 4'b0000};

   svws_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .diff  (diff),
      .den   (den),
      .quot  (div_q),
      .done  (div_done)
   );

   always_comb begin
      if (rd_ff.t_end < now_ff) speed = '0;
      else if (rd_ff.t_end == now_ff) speed = '1;
      else speed = div_q;
   end

   always_comb begin
      res_new = '0;
      res_new.kind = cmd.kind;
      case (cmd.kind)
         KIND_CMD: begin
            res_new.servo = SERVO_W'(idx_ff);
            res_new.goal  = rd_ff.goal;
            res_new.speed = speed;
            res_new.gain  = rd_ff.gain;
         end
         KIND_DONE:   res_new.servo = SERVO_W'(idx_ff);
         KIND_REJECT: res_new.servo = sid_ff;
         default:     res_new.servo = '0;
      endcase
   end

   // one result is held back so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if ((cmd.emit || cmd.flush) && pend_v_ff) rsp_v_ff <= 1'b1;
         else if (rsp_v_ff && rsp_ready) rsp_v_ff <= 1'b0;
         if (cmd.emit) pend_v_ff <= 1'b1;
         else if (cmd.flush) pend_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.emit || cmd.flush) && pend_v_ff) begin
         out_ff  <= pend_ff;
         last_ff <= cmd.flush;
      end
      if (cmd.emit) pend_ff <= res_new;
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_out_servo     = out_ff.servo;
   assign rsp_goal_position = out_ff.goal;
   assign rsp_moving_speed  = out_ff.speed;
   assign rsp_p_gain        = out_ff.gain;
   assign rsp_last          = last_ff;

   always_comb begin
      st.act        = act_ff;
      st.servo_ok   = {1'b0, sid_ff} < (SERVO_W+1)'(NUM_SERVOS);
      st.cnt_zero   = c == '0;
      st.cnt_one    = c == CNT_W'(1);
      st.cnt_full   = c >= CNT_W'(QUEUE_DEPTH);
      st.trim_hit   = rd_ff.t_start <= ttime_ff;
      st.retire_hit = rd_ff.started && (rd_ff.t_end < now_ff);
      st.start_hit  = !rd_ff.started && (rd_ff.t_start < now_ff);
      st.idx_last   = idx_ff == IDX_W'(NUM_SERVOS - 1);
      st.all_done   = emptied_ff && !nonempty_ff;
      st.div_done   = div_done;
      st.can_emit   = !(pend_v_ff && rsp_v_ff && !rsp_ready);
      st.pend_valid = pend_v_ff;
   end

endmodule

// File: rtl/core/svws_ctrl.sv
// controller state machine: sequences add, sample and tick requests over the datapath
// depends on svws_pkg
module svws_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output svws_pkg::cmd_type  cmd,
   input  svws_pkg::stat_type st
);
   import svws_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_A_CHK, S_A_EVAL, S_A_FIT, S_REJ,
      S_R_CHK, S_R_EVAL, S_R_DONE, S_R_NEXT, S_ALL,
      S_S_CHK, S_S_EVAL, S_S_DIV, S_S_NEXT, S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd      = '0;
      cmd.kind = KIND_CMD;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            case (st.act)
               ACT_SAMPLE: begin
                  cmd.pres_wr = st.servo_ok;
                  state_in    = S_IDLE;
               end
               ACT_ADD:  state_in = st.servo_ok ? S_A_CHK : S_REJ;
               ACT_TICK: begin
                  cmd.idx_clr  = 1'b1;
                  cmd.flag_clr = 1'b1;
                  state_in     = S_R_CHK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         // trim the back of the queue
         S_A_CHK: begin
            if (st.cnt_zero) state_in = S_A_FIT;
            else begin
               cmd.rd_back = 1'b1;
               state_in    = S_A_EVAL;
            end
         end
         S_A_EVAL: begin
            if (st.trim_hit) begin
               cmd.trim_dec = 1'b1;
               state_in     = S_A_CHK;
            end else state_in = S_A_FIT;
         end
         S_A_FIT: begin
            if (st.cnt_full) state_in = S_REJ;
            else begin
               cmd.append = 1'b1;
               state_in   = S_FLUSH;
            end
         end
         S_REJ: begin
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_REJECT;
               state_in = S_FLUSH;
            end
         end
         // retire pass
         S_R_CHK: begin
            if (st.cnt_zero) state_in = S_R_NEXT;
            else begin
               cmd.rd_front = 1'b1;
               state_in     = S_R_EVAL;
            end
         end
         S_R_EVAL: begin
            if (st.retire_hit) begin
               cmd.pop  = 1'b1;
               state_in = st.cnt_one ? S_R_DONE : S_R_CHK;
            end else state_in = S_R_NEXT;
         end
         S_R_DONE: begin
            if (st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_DONE;
               state_in = S_R_NEXT;
            end
         end
         S_R_NEXT: begin
            cmd.note_count = 1'b1;
            if (st.idx_last) state_in = S_ALL;
            else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_R_CHK;
            end
         end
         S_ALL: begin
            if (!st.all_done) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_S_CHK;
            end else if (st.can_emit) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ALL;
               cmd.idx_clr = 1'b1;
               state_in    = S_S_CHK;
            end
         end
         // start pass
         S_S_CHK: begin
            if (st.cnt_zero) state_in = S_S_NEXT;
            else begin
               cmd.rd_front = 1'b1;
               state_in     = S_S_EVAL;
            end
         end
         S_S_EVAL: begin
            if (st.start_hit) begin
               cmd.mark      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_S_DIV;
            end else state_in = S_S_NEXT;
         end
         S_S_DIV: begin
            if (st.div_done && st.can_emit) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_CMD;
               state_in = S_S_NEXT;
            end
         end
         S_S_NEXT: begin
            if (st.idx_last) state_in = S_FLUSH;
            else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_S_CHK;
            end
         end
         S_FLUSH: begin
            if (st.can_emit) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= state_in == S_IDLE;
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: rtl/core/servo_waypoint_scheduler.sv
// top level of the servo waypoint scheduler: controller plus datapath
// depends on svws_pkg, svws_ctrl, svws_datapath (which holds svws_divider)
//
// One request at a time. req_ready is high only while the block is idle. An add first trims
// entries from the back of the queue, and a full queue or a bad servo id rejects it. A tick
// walks all servo queues twice, a retire pass and then a start pass, and each waypoint that
// is started waits for the bit-serial speed divider (17 quotient bits). A stalled result
// channel holds the block in place while a result waits to be taken.
// Results leave through a one-entry hold stage and an output register, so the last result of a
// request is released at its end with rsp_last set. No clearing pass is needed after reset.
module servo_waypoint_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [svws_pkg::SERVO_W-1:0]  req_servo_id,
   input  logic [svws_pkg::TIME_W-1:0]   req_now_time,
   input  logic [svws_pkg::TIME_W-1:0]   req_target_time,
   input  logic signed [svws_pkg::POS_W-1:0] req_target_position,
   input  logic [15:0]                   req_target_gain,
   input  logic signed [svws_pkg::POS_W-1:0] req_sensed_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [svws_pkg::SERVO_W-1:0]  rsp_out_servo,
   output logic signed [svws_pkg::POS_W-1:0] rsp_goal_position,
   output logic [svws_pkg::SPEED_W-1:0]  rsp_moving_speed,
   output logic [15:0]                   rsp_p_gain,
   output logic                          rsp_last
);
   import svws_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // sequencing of the request phases
   svws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // queues, memory, divider and result staging
   svws_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_action          (req_action),
      .req_servo_id        (req_servo_id),
      .req_now_time        (req_now_time),
      .req_target_time     (req_target_time),
      .req_target_position (req_target_position),
      .req_target_gain     (req_target_gain),
      .req_sensed_position (req_sensed_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_servo       (rsp_out_servo),
      .rsp_goal_position   (rsp_goal_position),
      .rsp_moving_speed    (rsp_moving_speed),
      .rsp_p_gain          (rsp_p_gain),
      .rsp_last            (rsp_last),
      .cmd                 (cmd),
      .st                  (st)
   );

   // a result is only staged when the hold stage can move on
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.can_emit)
      else $error("result staged while output path is blocked");

   // the final result is only released when the output register is free
   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> st.can_emit)
      else $error("final result released while output register is blocked");

   // a new request is never taken with a result still held back
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !st.pend_valid)
      else $error("request accepted while a result is still held");

   // a command result always follows a finished division
   a_cmd_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == KIND_CMD) |-> st.div_done)
      else $error("servo command staged before the speed was ready");

endmodule
